/* design/emitter_spawn_rate_table_core_defines.svh */
// Assertion macros shared by the emitter spawn rate table design.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef EMITTER_SPAWN_RATE_TABLE_CORE_DEFINES_SVH
`define EMITTER_SPAWN_RATE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ESRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ESRT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ESRT_ASSERT(lbl, prop, msg)
`define ESRT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* design/esrt_pkg.sv */
package esrt_pkg;

	localparam int SLOT_W = 6;
	localparam int RATE_W = 24;
	localparam int ACC_W  = 32;
	localparam int ID_W   = 32;
	localparam int DT_W   = 16;
	localparam int CNT_W  = 24;
	localparam int PROD_W = 40;
	localparam int FRAC_W = 8;
	localparam int ACT_W  = 7;

	typedef enum logic [2:0] {
		OP_CREATE     = 3'd0,
		OP_DESTROY    = 3'd1,
		OP_SET_RATE   = 3'd2,
		OP_SET_ENABLE = 3'd3,
		OP_BURST      = 3'd4,
		OP_TICK       = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SREAD,
		S_SEXEC,
		S_TREAD,
		S_TMUL,
		S_TEMIT
	} state_t;

	// What the datapath does with the current slot in this cycle.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CREATE,
		ACT_FULL,
		ACT_BAD,
		ACT_SINGLE,
		ACT_TICK
	} action_t;

	typedef struct packed {
		logic    ld_item;
		logic    addr_cnt;
		logic    cnt_inc;
		action_t act;
	} dp_cmd_t;

	typedef struct packed {
		logic    out_free;
		opcode_t op;
		logic    slot_ok;
		logic    cur_active;
		logic    cnt_last;
	} dp_stat_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [SLOT_W-1:0]   slot;
		logic [RATE_W-1:0]   rate;
		logic                enable;
		logic [CNT_W-1:0]    burst_count;
		logic [DT_W-1:0]     delta_time;
	} item_t;

endpackage

/* design/esrt_channel_if.sv */
interface esrt_req_if;
	import esrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [2:0]          opcode;
	logic [SLOT_W-1:0]   slot;
	logic [RATE_W-1:0]   rate;
	logic                enable;
	logic [CNT_W-1:0]    burst_count;
	logic [DT_W-1:0]     delta_time;

	modport source (
		output valid, opcode, slot, rate, enable, burst_count, delta_time,
		input  ready
	);
	modport sink (
		input  valid, opcode, slot, rate, enable, burst_count, delta_time,
		output ready
	);
endinterface

interface esrt_rsp_if;
	import esrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   result_slot;
	logic [ID_W-1:0]     emitter_id;
	logic [CNT_W-1:0]    spawn_count;
	logic [ACC_W-1:0]    running_total;
	logic [ACT_W-1:0]    active_emitters;
	logic                last;

	modport source (
		output valid, status, result_slot, emitter_id, spawn_count, running_total,
		       active_emitters, last,
		input  ready
	);
	modport sink (
		input  valid, status, result_slot, emitter_id, spawn_count, running_total,
		       active_emitters, last,
		output ready
	);
endinterface

/* design/esrt_ram.sv */
module esrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

/* design/esrt_ctrl.sv */
module esrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  esrt_pkg::dp_stat_t stat,
	output esrt_pkg::dp_cmd_t  cmd
);
	import esrt_pkg::*;

	state_t state_q, state_d;
	logic   single_op;

	assign single_op = (stat.op == OP_DESTROY) || (stat.op == OP_SET_RATE) ||
	                   (stat.op == OP_SET_ENABLE) || (stat.op == OP_BURST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.op == OP_CREATE) begin
					state_d = S_SCAN;
				end else if (stat.op == OP_TICK) begin
					state_d = S_TREAD;
				end else if (single_op) begin
					if (stat.slot_ok) state_d = S_SREAD;
					else if (stat.out_free) state_d = S_IDLE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if ((!stat.cur_active || stat.cnt_last) && stat.out_free) state_d = S_IDLE;
			end
			S_SREAD: state_d = S_SEXEC;
			S_SEXEC: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_TREAD: state_d = S_TMUL;
			S_TMUL:  state_d = S_TEMIT;
			S_TEMIT: begin
				if (stat.out_free) state_d = stat.cnt_last ? S_IDLE : S_TREAD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.ld_item  = 1'b0;
		cmd.addr_cnt = 1'b1;
		cmd.cnt_inc  = 1'b0;
		cmd.act      = ACT_NONE;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.ld_item = req_valid;
			end
			S_DECODE: begin
				if (single_op && !stat.slot_ok && stat.out_free) cmd.act = ACT_BAD;
			end
			S_SCAN: begin
				if (!stat.cur_active) begin
					if (stat.out_free) cmd.act = ACT_CREATE;
				end else if (stat.cnt_last) begin
					if (stat.out_free) cmd.act = ACT_FULL;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_SREAD: cmd.addr_cnt = 1'b0;
			S_SEXEC: begin
				cmd.addr_cnt = 1'b0;
				if (stat.out_free) cmd.act = ACT_SINGLE;
			end
			S_TREAD, S_TMUL: begin
				cmd.act = ACT_NONE;
			end
			S_TEMIT: begin
				if (stat.out_free) begin
					cmd.act     = ACT_TICK;
					cmd.cnt_inc = !stat.cnt_last;
				end
			end
			default: begin
				cmd.act = ACT_NONE;
			end
		endcase
	end
endmodule

/* design/esrt_dp.sv */
`include "emitter_spawn_rate_table_core_defines.svh"

module esrt_dp #(
	parameter int MAX_EMITTERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esrt_pkg::dp_cmd_t  cmd,
	output esrt_pkg::dp_stat_t stat,
	input  esrt_pkg::item_t    item,
	esrt_rsp_if.source         rsp
);
	import esrt_pkg::*;

	localparam int IW = (MAX_EMITTERS > 1) ? $clog2(MAX_EMITTERS) : 1;
	localparam logic [ACT_W-1:0] SLOT_LIMIT = ACT_W'(MAX_EMITTERS);
	localparam logic [IW-1:0]    LAST_IDX   = IW'(MAX_EMITTERS - 1);

	item_t                   item_q;
	logic [IW-1:0]           cnt_q;
	logic [MAX_EMITTERS-1:0] active_q;
	logic [MAX_EMITTERS-1:0] enabled_q;
	logic [ID_W-1:0]         next_id_q;
	logic [ACT_W-1:0]        active_total_q;
	logic [ACC_W-1:0]        total_q;
	logic [PROD_W-1:0]       prod_q;

	logic [IW-1:0]     slot_idx;
	logic [IW-1:0]     addr;
	logic [RATE_W-1:0] rd_rate;
	logic [ACC_W-1:0]  rd_acc;
	logic [ID_W-1:0]   rd_id;
	logic              rate_we, acc_we, id_we;
	logic [ACC_W-1:0]  acc_wd;

	logic [ACC_W:0]    acc_sum, burst_sum, tot_sum;
	logic [ACC_W-1:0]  acc_sat, burst_sat, tot_sat;
	logic              tick_go;
	logic [CNT_W-1:0]  tick_cnt;
	logic [ACT_W-1:0]  total_next;
	logic              out_free;

	status_t           o_status;
	logic [SLOT_W-1:0] o_slot;
	logic [ID_W-1:0]   o_id;
	logic [CNT_W-1:0]  o_count;
	logic [ACC_W-1:0]  o_total;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic [ID_W-1:0]   rsp_id_q;
	logic [CNT_W-1:0]  rsp_count_q;
	logic [ACC_W-1:0]  rsp_total_q;
	logic [ACT_W-1:0]  rsp_active_q;
	logic              rsp_last_q;

	assign slot_idx = item_q.slot[IW-1:0];
	assign addr     = cmd.addr_cnt ? cnt_q : slot_idx;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign stat.out_free   = out_free;
	assign stat.op         = item_q.opcode;
	assign stat.slot_ok    = ({1'b0, item_q.slot} < SLOT_LIMIT) && active_q[slot_idx];
	assign stat.cur_active = active_q[cnt_q];
	assign stat.cnt_last   = (cnt_q == LAST_IDX);

	esrt_ram #(.WIDTH(RATE_W), .DEPTH(MAX_EMITTERS)) u_rate_ram (
		.clk(clk), .we(rate_we), .addr(addr), .wdata(item_q.rate), .rdata(rd_rate)
	);
	esrt_ram #(.WIDTH(ACC_W), .DEPTH(MAX_EMITTERS)) u_acc_ram (
		.clk(clk), .we(acc_we), .addr(addr), .wdata(acc_wd), .rdata(rd_acc)
	);
	esrt_ram #(.WIDTH(ID_W), .DEPTH(MAX_EMITTERS)) u_id_ram (
		.clk(clk), .we(id_we), .addr(addr), .wdata(next_id_q), .rdata(rd_id)
	);

	// Rate times frame time, registered before the accumulator add.
	always_ff @(posedge clk) begin
		prod_q <= rd_rate * item_q.delta_time;
	end

	always_comb begin
		tick_go   = active_q[cnt_q] && enabled_q[cnt_q];
		acc_sum   = {1'b0, rd_acc} + (ACC_W + 1)'(prod_q[PROD_W-1:16]);
		acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
		tick_cnt  = tick_go ? acc_sat[ACC_W-1:FRAC_W] : '0;
		burst_sum = {1'b0, rd_acc} + (ACC_W + 1)'({item_q.burst_count, {FRAC_W{1'b0}}});
		burst_sat = burst_sum[ACC_W] ? '1 : burst_sum[ACC_W-1:0];
		tot_sum   = {1'b0, total_q} + (ACC_W + 1)'(tick_cnt);
		tot_sat   = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
	end

	always_comb begin
		rate_we = 1'b0;
		acc_we  = 1'b0;
		id_we   = 1'b0;
		acc_wd  = '0;
		case (cmd.act)
			ACT_CREATE: begin
				rate_we = 1'b1;
				acc_we  = 1'b1;
				id_we   = 1'b1;
			end
			ACT_SINGLE: begin
				rate_we = (item_q.opcode == OP_SET_RATE);
				acc_we  = (item_q.opcode == OP_BURST);
				acc_wd  = burst_sat;
			end
			ACT_TICK: begin
				acc_we = tick_go;
				acc_wd = {{(ACC_W - FRAC_W){1'b0}}, acc_sat[FRAC_W-1:0]};
			end
			default: begin
				acc_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		total_next = active_total_q;
		if (cmd.act == ACT_CREATE) begin
			total_next = active_total_q + 1'b1;
		end else if (cmd.act == ACT_SINGLE && item_q.opcode == OP_DESTROY) begin
			total_next = active_total_q - 1'b1;
		end
	end

	always_comb begin
		o_status = ST_OK;
		o_slot   = SLOT_W'(cnt_q);
		o_id     = '0;
		o_count  = '0;
		o_total  = '0;
		case (cmd.act)
			ACT_CREATE: o_id = next_id_q;
			ACT_FULL: begin
				o_status = ST_FULL;
				o_slot   = '0;
			end
			ACT_BAD: begin
				o_status = ST_BAD;
				o_slot   = item_q.slot;
			end
			ACT_SINGLE: begin
				o_slot = item_q.slot;
				o_id   = rd_id;
			end
			ACT_TICK: begin
				o_id    = active_q[cnt_q] ? rd_id : '0;
				o_count = tick_cnt;
				o_total = tot_sat;
			end
			default: begin
				o_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			item_q <= item;
		end
		if (cmd.ld_item) begin
			total_q <= '0;
		end else if (cmd.act == ACT_TICK) begin
			total_q <= tot_sat;
		end
		if (cmd.act != ACT_NONE) begin
			rsp_status_q <= o_status;
			rsp_slot_q   <= o_slot;
			rsp_id_q     <= o_id;
			rsp_count_q  <= o_count;
			rsp_total_q  <= o_total;
			rsp_active_q <= total_next;
			rsp_last_q   <= (cmd.act != ACT_TICK) || (cnt_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			active_q       <= '0;
			enabled_q      <= '0;
			next_id_q      <= '0;
			active_total_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cmd.ld_item) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			active_total_q <= total_next;
			if (cmd.act == ACT_CREATE) begin
				active_q[cnt_q]  <= 1'b1;
				enabled_q[cnt_q] <= 1'b1;
				next_id_q        <= next_id_q + 1'b1;
			end else if (cmd.act == ACT_SINGLE) begin
				if (item_q.opcode == OP_DESTROY) begin
					active_q[slot_idx]  <= 1'b0;
					enabled_q[slot_idx] <= 1'b0;
				end else if (item_q.opcode == OP_SET_ENABLE) begin
					enabled_q[slot_idx] <= item_q.enable;
				end
			end
			if (cmd.act != ACT_NONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.result_slot     = rsp_slot_q;
	assign rsp.emitter_id      = rsp_id_q;
	assign rsp.spawn_count     = rsp_count_q;
	assign rsp.running_total   = rsp_total_q;
	assign rsp.active_emitters = rsp_active_q;
	assign rsp.last            = rsp_last_q;

	// The active counter must track the active flags exactly.
	`ESRT_ASSERT(a_total_matches_flags, $countones(active_q) == 32'(active_total_q), "count drift")
	`ESRT_ASSERT(a_total_in_range, active_total_q <= SLOT_LIMIT, "active count above slot count")
	// A slot can only be enabled while it is active.
	`ESRT_ASSERT_NEVER(a_enabled_not_active, (enabled_q & ~active_q) != '0, "enabled idle slot")
	// A result is only produced when the output register can take it.
	`ESRT_ASSERT_NEVER(a_emit_when_full, (cmd.act != ACT_NONE) && !out_free, "result overrun")
endmodule

/* design/emitter_spawn_rate_table_core.sv */
// Emitter spawn rate table. Commands arrive on the req channel and results leave
// on the rsp channel; both are valid/ready channels and a transaction moves on a
// rising edge where valid and ready are both high. One command is worked at a time:
// req.ready is high only while the controller is idle, and a waiting result in the
// output register does not hold off the next command.
// Create scans the active flags one slot per cycle and takes the first free slot.
// Destroy, set rate, set enable and burst step through decode, memory read and
// execute; an invalid slot is answered from the decode step. A tick walks every
// slot to read the slot memories, multiply, then accumulate and emit, and produces
// one result per slot with last set on the final one. Opcodes 6 and 7 produce nothing.
// The per-slot steps come from the registered read of the slot memories and the
// register after the rate multiplier.
// When the receiver stalls, the result holds in the output register and the
// controller waits in the step that would emit the next result until the output
// register is free.
// Reset clears the active and enabled flags, the id counter and the active count;
// the slot memories need no clearing, since data of slots never created is unused.
module emitter_spawn_rate_table_core #(
	parameter int MAX_EMITTERS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	esrt_req_if.sink   req,
	esrt_rsp_if.source rsp
);
	import esrt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	item_t    item;
	logic     req_ready;

	// The command payload is bundled once so the datapath can capture it in one step.
	always_comb begin
		item.opcode      = opcode_t'(req.opcode);
		item.slot        = req.slot;
		item.rate        = req.rate;
		item.enable      = req.enable;
		item.burst_count = req.burst_count;
		item.delta_time  = req.delta_time;
	end

	assign req.ready = req_ready;

	// The controller sequences the scan, the single-slot commands and the tick walk.
	esrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the slot flags, the slot memories, the multiplier and the
	// output register that drives the rsp channel.
	esrt_dp #(.MAX_EMITTERS(MAX_EMITTERS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.item   (item),
		.rsp    (rsp)
	);
endmodule
